### src/ps2_mouse_packet_assembler_defines.svh
// ----------------------------------------------------------------------------
// PS/2 mouse packet assembler assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_ASSEMBLER_DEFINES_SVH
`define PS2_MOUSE_PACKET_ASSEMBLER_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define PMA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds on the following clock.
`define PMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ps2mpa_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet assembler package
// Beat types, packet state type and header/mode codes shared by the block.
// ----------------------------------------------------------------------------
package ps2mpa_pkg;

   // Input beat function codes.
   localparam logic FUNC_BYTE   = 1'b0;
   localparam logic FUNC_RESYNC = 1'b1;

   // Packet mode register codes.
   localparam logic [1:0] MODE_STANDARD    = 2'd0;
   localparam logic [1:0] MODE_WHEEL       = 2'd1;
   localparam logic [1:0] MODE_FIVE_BUTTON = 2'd2;

   // Byte position within a packet.
   localparam logic [1:0] POS_HEADER = 2'd0;
   localparam logic [1:0] POS_X      = 2'd1;
   localparam logic [1:0] POS_Y      = 2'd2;
   localparam logic [1:0] POS_EXTRA  = 2'd3;

   // Header byte fields.
   localparam logic [7:0] HDR_OVERFLOW_MASK   = 8'hC0;  // Y (0x80) and X (0x40) overflow
   localparam logic [7:0] HDR_ALWAYS_ONE_MASK = 8'h08;
   localparam logic [7:0] HDR_MIDDLE_MASK     = 8'h04;
   localparam logic [7:0] HDR_RIGHT_MASK      = 8'h02;
   localparam logic [7:0] HDR_LEFT_MASK       = 8'h01;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic       from_aux;
   } req_type;

   typedef struct packed {
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
      logic              left_button;
      logic              right_button;
      logic              middle_button;
      logic              scroll_up;
      logic              scroll_down;
   } rsp_type;

   // Packet assembly state carried from beat to beat.
   typedef struct packed {
      logic [1:0] position;
      logic [7:0] header;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
   } asm_state_type;

endpackage

### src/ps2_mouse_packet_assembler.sv
// A closing beat passes the input register, then the decoder, into the result register.
// Throughput: one input beat per cycle; input stalls only while a held result is stalled.
// The byte position is a 2-bit register looping through the decoder, as the packet bytes do.
// Synchronous active-high reset clears the position, the mode register (standard
// three-byte mode) and both valid flags; the captured packet bytes are not reset.
// ----------------------------------------------------------------------------
// PS/2 mouse packet assembler
// Builds three- or four-byte PS/2 mouse packets from received bytes and
// emits movement and button reports for packets that did not overflow.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_assembler (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ps2mpa_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ps2mpa_pkg::rsp_type rsp_data,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data
);
   import ps2mpa_pkg::*;

`include "ps2_mouse_packet_assembler_defines.svh"

   // Mode register. The user must rewrite it only while the block is idle, so the
   // decoder may read it directly; the block itself does not enforce this.
   logic [1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_STANDARD;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Input register. A beat sits here until it is decoded and is decoded from
   // here, so the decoder sees registered data; req_stall still follows rsp_stall.
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    step_fire;
   logic    out_free;

   // The result register can take a new beat when it is empty or draining.
   assign out_free  = !rsp_valid || !rsp_stall;
   assign step_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Packet assembly state. Only the position needs a reset; the stored
   // bytes are always written before a packet can complete.
   asm_state_type state_ff;
   asm_state_type state_in;
   logic          result_valid;
   rsp_type       result;

   ps2mpa_decode u_decode (
      .state_cur    (state_ff),
      .req          (in_data_ff),
      .packet_mode  (mode_ff),
      .state_nxt    (state_in),
      .result_valid (result_valid),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.position <= POS_HEADER;
      end else if (step_fire) begin
         state_ff.position <= state_in.position;
      end
      if (step_fire) begin
         state_ff.header <= state_in.header;
         state_ff.x_byte <= state_in.x_byte;
         state_ff.y_byte <= state_in.y_byte;
      end
   end

   // Result register. A beat that closes a clean packet lands here and is
   // held until the consumer takes it.
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_fire) begin
         rsp_valid_in = result_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && result_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The input side is held back only while a beat waits to be decoded.
   `PMA_ASSERT_NOW(a_stall_needs_beat, clock, reset, req_stall, in_valid_ff,
      "req_stall raised with no beat in the input register")

   // A clean closing beat always shows up as a result beat.
   `PMA_ASSERT_NEXT(a_result_loaded, clock, reset, step_fire && result_valid, rsp_valid,
      "completed packet did not reach the result register")

   // Standard mode never parks the position on the fourth byte.
   `PMA_ASSERT_NEXT(a_std_no_extra, clock, reset,
      step_fire && (mode_ff == MODE_STANDARD) && (state_ff.position != POS_EXTRA),
      state_ff.position != POS_EXTRA,
      "standard mode advanced to the fourth byte")

   // The position moves only when a beat is decoded.
   `PMA_ASSERT_NEXT(a_pos_hold, clock, reset, !step_fire, $stable(state_ff.position),
      "byte position changed without a decoded beat")

endmodule

### src/ps2mpa_decode.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet step decoder
// Combinational update of the packet state for one beat, plus the result.
// ----------------------------------------------------------------------------
module ps2mpa_decode (
   input  ps2mpa_pkg::asm_state_type state_cur,
   input  ps2mpa_pkg::req_type       req,
   input  logic [1:0]                packet_mode,
   output ps2mpa_pkg::asm_state_type state_nxt,
   output logic                      result_valid,
   output ps2mpa_pkg::rsp_type       result
);
   import ps2mpa_pkg::*;

   logic       four_byte;
   logic       complete;
   logic [7:0] fourth;
   logic [7:0] y_used;

   assign four_byte = (packet_mode == MODE_WHEEL) || (packet_mode == MODE_FIVE_BUTTON);

   always_comb begin
      state_nxt = state_cur;
      complete  = 1'b0;
      fourth    = 8'h00;
      y_used    = state_cur.y_byte;
      if (req.func == FUNC_RESYNC) begin
         state_nxt.position = POS_HEADER;
      end else if (req.from_aux) begin
         unique case (state_cur.position)
            POS_HEADER: begin
               state_nxt.header   = req.data_byte;
               state_nxt.position = ((req.data_byte & HDR_ALWAYS_ONE_MASK) != 8'h00) ?
                                    POS_X : POS_HEADER;
            end
            POS_X: begin
               state_nxt.x_byte   = req.data_byte;
               state_nxt.position = POS_Y;
            end
            POS_Y: begin
               state_nxt.y_byte   = req.data_byte;
               y_used             = req.data_byte;
               if (four_byte) begin
                  state_nxt.position = POS_EXTRA;
               end else begin
                  state_nxt.position = POS_HEADER;
                  complete           = 1'b1;
               end
            end
            POS_EXTRA: begin
               state_nxt.position = POS_HEADER;
               complete           = 1'b1;
               fourth             = req.data_byte;
            end
            default: begin
               state_nxt.position = POS_HEADER;
            end
         endcase
      end
   end

   // A completed packet with either overflow flag is dropped.
   assign result_valid = complete && ((state_cur.header & HDR_OVERFLOW_MASK) == 8'h00);

   always_comb begin
      result.delta_x       = state_cur.x_byte;
      result.delta_y       = y_used;
      result.left_button   = (state_cur.header & HDR_LEFT_MASK) != 8'h00;
      result.right_button  = (state_cur.header & HDR_RIGHT_MASK) != 8'h00;
      result.middle_button = (state_cur.header & HDR_MIDDLE_MASK) != 8'h00;
      result.scroll_up     = (packet_mode == MODE_WHEEL) && fourth[7];
      result.scroll_down   = (packet_mode == MODE_WHEEL) && !fourth[7] && (fourth != 8'h00);
   end

endmodule
